### sv/lidar_scan_packet_decoder_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef LIDAR_SCAN_PACKET_DECODER_UNIT_DEFINES_SVH
`define LIDAR_SCAN_PACKET_DECODER_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LSPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LSPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lspd_pkg.sv
`default_nettype none
package lspd_pkg;

  localparam int ANGLE_BINS         = 360;
  localparam int REPLY_HEADER_BYTES = 7;

  localparam int BIN_W      = $clog2(ANGLE_BINS);
  localparam int Q6_W       = 15;
  localparam int DIST_W     = 16;
  localparam int IDX_W      = 9;
  localparam int DVD_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int OUT_DATA_W = 56;

  localparam logic [Q6_W-1:0]   FULL_TURN_Q6    = Q6_W'(ANGLE_BINS * 64);
  localparam logic [DIST_W-1:0] SEARCH_LIMIT_Q2 = DIST_W'(40000);
  localparam logic [BIN_W-1:0]  LAST_BIN        = BIN_W'(ANGLE_BINS - 1);
  localparam logic [BIN_W:0]    BINS_WIDE       = (BIN_W + 1)'(ANGLE_BINS);
  localparam logic [IDX_W-1:0]  HDR_LAST_INDEX  = IDX_W'(REPLY_HEADER_BYTES - 1);
  localparam logic [4:0]        DIV_LAST_STEP   = 5'(DVD_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_TYPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TYPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_MM    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MM     = 3'd5;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic clr_index;
    logic inc_index;
    logic load_kind;
    logic load_count;
    logic load_low;
    logic load_start;
    logic load_end;
    logic load_diff;
    logic sample_start;
    logic write_sample;
    logic scan_start;
    logic clear_start;
    logic emit_sample;
    logic emit_reject;
  } lspd_cmd_t;

  typedef struct packed {
    logic eq_sync_first;
    logic eq_sync_second;
    logic eq_reply;
    logic hdr_done;
    logic kind_point;
    logic count_zero;
    logic index_odd;
    logic sample_last;
    logic cur_last;
    logic div_done;
    logic clear_done;
    logic scan_done;
    logic out_free;
  } lspd_sts_t;

endpackage
`default_nettype wire

### sv/lspd_ram.sv
`default_nettype none
module lspd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 360
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/lspd_ctrl.sv
`default_nettype none
module lspd_ctrl import lspd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire lspd_sts_t sts,
  output lspd_cmd_t      cmd
);

  typedef enum logic [11:0] {
    PH_REPLY   = 12'b0000_0000_0001,
    PH_SYNC1   = 12'b0000_0000_0010,
    PH_SYNC2   = 12'b0000_0000_0100,
    PH_TYPE    = 12'b0000_0000_1000,
    PH_COUNT   = 12'b0000_0001_0000,
    PH_FSA_L   = 12'b0000_0010_0000,
    PH_FSA_H   = 12'b0000_0100_0000,
    PH_LSA_L   = 12'b0000_1000_0000,
    PH_LSA_H   = 12'b0001_0000_0000,
    PH_CS_L    = 12'b0010_0000_0000,
    PH_CS_H    = 12'b0100_0000_0000,
    PH_SAMPLES = 12'b1000_0000_0000
  } phase_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b000_0001,
    ST_CLEAR  = 7'b000_0010,
    ST_DIV    = 7'b000_0100,
    ST_WRITE  = 7'b000_1000,
    ST_SCAN   = 7'b001_0000,
    ST_EMIT   = 7'b010_0000,
    ST_REJECT = 7'b100_0000
  } state_t;

  phase_t phase, phase_next;
  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_REPLY;
      state <= ST_IDLE;
    end else begin
      phase <= phase_next;
      state <= state_next;
    end
  end

  always_comb begin
    phase_next = phase;
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (phase)
            PH_REPLY: begin
              if (sts.hdr_done) begin
                cmd.clr_index = 1'b1;
                if (sts.eq_reply) begin
                  phase_next = PH_SYNC1;
                end else begin
                  state_next = ST_REJECT;
                end
              end else begin
                cmd.inc_index = 1'b1;
              end
            end
            PH_SYNC1: begin
              if (sts.eq_sync_first) begin
                phase_next = PH_SYNC2;
              end
            end
            PH_SYNC2: begin
              if (sts.eq_sync_second) begin
                phase_next = PH_TYPE;
              end else if (!sts.eq_sync_first) begin
                phase_next = PH_SYNC1;
              end
            end
            PH_TYPE: begin
              cmd.load_kind = 1'b1;
              phase_next    = PH_COUNT;
            end
            PH_COUNT: begin
              cmd.load_count = 1'b1;
              phase_next     = PH_FSA_L;
            end
            PH_FSA_L: begin
              cmd.load_low = 1'b1;
              phase_next   = PH_FSA_H;
            end
            PH_FSA_H: begin
              cmd.load_start = 1'b1;
              phase_next     = PH_LSA_L;
            end
            PH_LSA_L: begin
              cmd.load_low = 1'b1;
              phase_next   = PH_LSA_H;
            end
            PH_LSA_H: begin
              cmd.load_end = 1'b1;
              phase_next   = PH_CS_L;
            end
            PH_CS_L: begin
              cmd.load_diff = 1'b1;
              phase_next    = PH_CS_H;
            end
            PH_CS_H: begin
              cmd.clr_index = 1'b1;
              phase_next    = sts.count_zero ? PH_SYNC1 : PH_SAMPLES;
              if (sts.kind_point) begin
                cmd.clear_start = 1'b1;
                state_next      = ST_CLEAR;
              end
            end
            PH_SAMPLES: begin
              if (!sts.index_odd) begin
                cmd.load_low  = 1'b1;
                cmd.inc_index = 1'b1;
              end else begin
                if (sts.sample_last) begin
                  cmd.clr_index = 1'b1;
                  phase_next    = PH_SYNC1;
                end else begin
                  cmd.inc_index = 1'b1;
                end
                if (sts.kind_point) begin
                  cmd.sample_start = 1'b1;
                  state_next       = ST_DIV;
                end
              end
            end
            default: begin
              cmd.clr_index = 1'b1;
              phase_next    = PH_SYNC1;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write_sample = 1'b1;
        if (sts.cur_last) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_sample = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_REJECT: begin
        if (sts.out_free) begin
          cmd.emit_reject = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/lspd_datapath.sv
`default_nettype none
module lspd_datapath import lspd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            rx_byte,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire lspd_cmd_t             cmd,
  output lspd_sts_t                  sts,
  input  wire logic                  m_tready,
  output logic                       m_tvalid,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tuser,
  output logic                       m_tlast
);

  logic [7:0]            sync_first, sync_second, point_type, reply_type;
  logic [CFG_DATA_W-1:0] floor_mm, near_mm;

  logic [IDX_W-1:0]  byte_index;
  logic [7:0]        packet_kind, sample_total, low_hold;
  logic [Q6_W-1:0]   start_q6, end_q6, diff_q6;
  logic [DIST_W-1:0] cur_dist;
  logic              cur_last;
  logic [DVD_W-1:0]  dvd;
  logic [7:0]        rem;
  logic [4:0]        div_cnt;
  logic              div_busy;
  logic [BIN_W-1:0]  sweep, cmp_addr;
  logic              clear_busy, scan_busy, cmp_valid;
  logic [DIST_W-1:0] best;
  logic [BIN_W-1:0]  best_bin;
  logic              found;

  logic [15:0]       half_word;
  logic [Q6_W-1:0]   word_q6;
  logic [7:0]        divisor;
  logic [8:0]        rem_sh;
  logic              rem_ge;
  logic [Q6_W-1:0]   quotient;
  logic [15:0]       angle_q6;
  logic [BIN_W:0]    degree;
  logic [BIN_W-1:0]  bin;
  logic [DIST_W-1:0] rd_data, floor_q2, near_q2;
  logic              ram_we;
  logic [BIN_W-1:0]  ram_waddr;
  logic [DIST_W-1:0] ram_wdata;
  logic              show_min;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= 8'd170;
      sync_second <= 8'd85;
      point_type  <= 8'd0;
      reply_type  <= 8'd129;
      floor_mm    <= 14'd10;
      near_mm     <= 14'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data[7:0];
        CFG_SYNC_SECOND: sync_second <= cfg_data[7:0];
        CFG_POINT_TYPE:  point_type  <= cfg_data[7:0];
        CFG_REPLY_TYPE:  reply_type  <= cfg_data[7:0];
        CFG_FLOOR_MM:    floor_mm    <= cfg_data;
        CFG_NEAR_MM:     near_mm     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Angle word to 1/64 degree, reduced to one turn.
  assign half_word = {1'b0, rx_byte, low_hold[7:1]};
  assign word_q6   = (half_word[Q6_W-1:0] >= FULL_TURN_Q6) ?
                     half_word[Q6_W-1:0] - FULL_TURN_Q6 : half_word[Q6_W-1:0];

  // Packet header fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      packet_kind  <= '0;
      sample_total <= '0;
      low_hold     <= '0;
      start_q6     <= '0;
      end_q6       <= '0;
    end else begin
      if (cmd.clr_index) begin
        byte_index <= '0;
      end else if (cmd.inc_index) begin
        byte_index <= byte_index + IDX_W'(1);
      end
      if (cmd.load_kind)  packet_kind  <= rx_byte;
      if (cmd.load_count) sample_total <= rx_byte;
      if (cmd.load_low)   low_hold     <= rx_byte;
      if (cmd.load_start) start_q6     <= word_q6;
      if (cmd.load_end)   end_q6       <= word_q6;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_diff) begin
      if (end_q6 >= start_q6) begin
        diff_q6 <= end_q6 - start_q6;
      end else begin
        diff_q6 <= Q6_W'({1'b0, end_q6} + {1'b0, FULL_TURN_Q6} - {1'b0, start_q6});
      end
    end
  end

  // Restoring divider, one quotient bit a cycle: diff*idx / (n-1).
  assign divisor = sample_total - 8'd1;
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.sample_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == DIV_LAST_STEP) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_start) begin
      dvd      <= DVD_W'(diff_q6) * DVD_W'(byte_index[IDX_W-1:1]);
      rem      <= '0;
      div_cnt  <= '0;
      cur_dist <= {rx_byte, low_hold};
      cur_last <= sts.sample_last;
    end else if (div_busy) begin
      rem     <= rem_ge ? 8'(rem_sh - {1'b0, divisor}) : rem_sh[7:0];
      dvd     <= {dvd[DVD_W-2:0], rem_ge};
      div_cnt <= div_cnt + 5'd1;
    end
  end

  // Single-sample packets sit at the start angle.
  assign quotient = (sample_total > 8'd1) ? dvd[Q6_W-1:0] : '0;
  assign angle_q6 = {1'b0, start_q6} + {1'b0, quotient};
  assign degree   = angle_q6[15:6];
  assign bin      = (degree >= BINS_WIDE) ? BIN_W'(degree - BINS_WIDE) : degree[BIN_W-1:0];

  // Sweep counter for the clearing pass and the minimum walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b0;
      scan_busy  <= 1'b0;
      cmp_valid  <= 1'b0;
    end else begin
      cmp_valid <= scan_busy;
      if (cmd.clear_start) begin
        clear_busy <= 1'b1;
      end else if (clear_busy && sweep == LAST_BIN) begin
        clear_busy <= 1'b0;
      end
      if (cmd.scan_start) begin
        scan_busy <= 1'b1;
      end else if (scan_busy && sweep == LAST_BIN) begin
        scan_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr <= sweep;
    if (cmd.clear_start || cmd.scan_start) begin
      sweep <= '0;
    end else if (clear_busy || scan_busy) begin
      sweep <= sweep + BIN_W'(1);
    end
  end

  assign ram_we    = cmd.write_sample || clear_busy;
  assign ram_waddr = clear_busy ? sweep : bin;
  assign ram_wdata = clear_busy ? '0 : cur_dist;

  lspd_ram #(
    .WIDTH(DIST_W),
    .DEPTH(ANGLE_BINS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(sweep),
    .rdata(rd_data)
  );

  assign floor_q2 = {floor_mm, 2'b00};
  assign near_q2  = {near_mm, 2'b00};

  // Keep the first bin that holds the smallest qualifying distance.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best     <= SEARCH_LIMIT_Q2;
      best_bin <= '0;
      found    <= 1'b0;
    end else if (cmp_valid && rd_data > floor_q2 && rd_data < best) begin
      best     <= rd_data;
      best_bin <= cmp_addr;
      found    <= 1'b1;
    end
  end

  // Output register.
  assign show_min = cur_last && found;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_sample || cmd.emit_reject) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sample) begin
      m_tuser <= KIND_SAMPLE;
      m_tlast <= cur_last;
      m_tdata <= {4'b0,
                  show_min && (best < near_q2),
                  show_min ? best_bin : BIN_W'(0),
                  show_min ? best : DIST_W'(0),
                  show_min,
                  cur_dist,
                  bin};
    end else if (cmd.emit_reject) begin
      m_tuser <= KIND_REJECT;
      m_tlast <= 1'b0;
      m_tdata <= '0;
    end
  end

  assign sts.eq_sync_first  = (rx_byte == sync_first);
  assign sts.eq_sync_second = (rx_byte == sync_second);
  assign sts.eq_reply       = (rx_byte == reply_type);
  assign sts.hdr_done       = (byte_index >= HDR_LAST_INDEX);
  assign sts.kind_point     = (packet_kind == point_type);
  assign sts.count_zero     = (sample_total == 8'd0);
  assign sts.index_odd      = byte_index[0];
  assign sts.sample_last    = ({1'b0, byte_index[IDX_W-1:1]} + IDX_W'(1)) >=
                              {1'b0, sample_total};
  assign sts.cur_last       = cur_last;
  assign sts.div_done       = div_busy && (div_cnt == DIV_LAST_STEP);
  assign sts.clear_done     = clear_busy && (sweep == LAST_BIN);
  assign sts.scan_done      = cmp_valid && (cmp_addr == LAST_BIN);
  assign sts.out_free       = !m_tvalid || m_tready;

endmodule
`default_nettype wire

### sv/lidar_scan_packet_decoder_unit.sv
// Lidar scan packet decoder: takes the serial stream one byte per transaction,
// checks the 7-byte scan reply header, then frames scan packets and, for point
// cloud packets, returns one result per sample with its degree bin and
// distance; the last sample of a packet also carries the table minimum and
// the near-object flag. A reply header with the wrong type byte gives a
// reject result instead. A point cloud sample goes through the bit-serial
// divider that interpolates the angle (23 steps), then the table write and
// the output load. The last sample adds a walk of the 360-entry distance
// table, read one entry a cycle from its read port. Completing a point cloud
// header starts a clearing pass over all 360 table entries, during which no
// byte is taken. A finished result waits in the output register while the
// next byte is taken; a new result waits until that register is free, and
// no byte is taken meanwhile.
`default_nettype none
module lidar_scan_packet_decoder_unit import lspd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // s_tdata: rx_byte[7:0]
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,
  // m_tdata: angle_bin[8:0], distance_q2[24:9], minimum_found[25],
  //          minimum_q2[41:26], minimum_bin[50:42], object_near[51], zero fill
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // m_tuser: result_kind (0 sample, 1 reply header rejected)
  output logic                       m_tuser,
  // m_tlast: packet_last
  output logic                       m_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  lspd_cmd_t cmd;
  lspd_sts_t sts;

  // Parser and sequencing of the divider, table and output register.
  lspd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Header fields, angle interpolation, distance table and minimum walk.
  lspd_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

### sv/lspd_checker.sv
`default_nettype none
`include "lidar_scan_packet_decoder_unit_defines.svh"
module lspd_checker import lspd_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tuser,
  input wire logic                  m_tlast
);

  `LSPD_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `LSPD_ASSERT_SAME(a_reject_clean, m_tvalid && m_tuser, m_tdata == '0 && !m_tlast, "reject carries data")
  `LSPD_ASSERT_SAME(a_mid_no_min, m_tvalid && !m_tlast, m_tdata[51:25] == '0, "minimum on a non-last result")
  `LSPD_ASSERT_SAME(a_near_found, m_tvalid && m_tdata[51], m_tdata[25], "near flag without a minimum")
  `LSPD_ASSERT_SAME(a_bin_range, m_tvalid, m_tdata[8:0] < 9'd360 && m_tdata[50:42] < 9'd360, "bin out of range")

endmodule

bind lidar_scan_packet_decoder_unit lspd_checker u_lspd_checker (.*);
`default_nettype wire

### tb/tb_lidar_scan_packet_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_lidar_scan_packet_decoder_unit;
  import lspd_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [8:0] bin;
    logic [15:0] distance;
    logic       last;
    logic       min_found;
    logic [15:0] min_q2;
    logic [8:0] min_bin;
    logic       near;
  } scan_result_t;

  typedef enum logic [3:0] {
    P_REPLY, P_SYNC1, P_SYNC2, P_TYPE, P_COUNT, P_FSA_L, P_FSA_H,
    P_LSA_L, P_LSA_H, P_CS_L, P_CS_H, P_SAMPLES
  } parse_phase_t;

  localparam int LIMIT_CYCLES = 1_500_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  lidar_scan_packet_decoder_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: configuration and decoder copy
  logic [7:0]  sync_first_r, sync_second_r, point_type_r, reply_type_r;
  logic [13:0] floor_mm_r, near_mm_r;
  parse_phase_t phase;
  int unsigned hdr_count, sample_byte, pkt_kind, pkt_count, start_q6, end_q6, low_hold;
  logic [15:0] dist_table [ANGLE_BINS];

  scan_result_t expected_results[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned cycle = 0;
  int unsigned burst_left = 0;

  function automatic int unsigned angle_q6(int unsigned lo, int unsigned hi);
    return (((hi << 8) | lo) >> 1) % (ANGLE_BINS * 64);
  endfunction

  // Advance the decoder copy by one byte and queue what it should produce.
  task automatic predict_byte(input logic [7:0] b);
    scan_result_t r;
    int unsigned idx, diff, ang, bin, best, fl;
    r = '0;
    case (phase)
      P_REPLY: begin
        hdr_count++;
        if (hdr_count >= REPLY_HEADER_BYTES) begin
          hdr_count = 0;
          if (b == reply_type_r) phase = P_SYNC1;
          else begin
            r.kind = KIND_REJECT;
            expected_results.push_back(r);
          end
        end
      end
      P_SYNC1: if (b == sync_first_r) phase = P_SYNC2;
      P_SYNC2: begin
        if (b == sync_second_r) phase = P_TYPE;
        else if (b != sync_first_r) phase = P_SYNC1;
      end
      P_TYPE: begin pkt_kind = b; phase = P_COUNT; end
      P_COUNT: begin pkt_count = b; phase = P_FSA_L; end
      P_FSA_L: begin low_hold = b; phase = P_FSA_H; end
      P_FSA_H: begin start_q6 = angle_q6(low_hold, b); phase = P_LSA_L; end
      P_LSA_L: begin low_hold = b; phase = P_LSA_H; end
      P_LSA_H: begin end_q6 = angle_q6(low_hold, b); phase = P_CS_L; end
      P_CS_L: phase = P_CS_H;
      P_CS_H: begin
        if (pkt_kind == point_type_r)
          foreach (dist_table[i]) dist_table[i] = '0;
        sample_byte = 0;
        phase = (pkt_count == 0) ? P_SYNC1 : P_SAMPLES;
      end
      default: begin
        idx = sample_byte >> 1;
        if ((sample_byte & 1) == 0) begin
          low_hold = b;
          sample_byte++;
        end else begin
          sample_byte++;
          r.last = (idx + 1 >= pkt_count);
          if (r.last) phase = P_SYNC1;
          if (pkt_kind == point_type_r) begin
            diff = (end_q6 >= start_q6) ? end_q6 - start_q6
                                        : end_q6 + ANGLE_BINS * 64 - start_q6;
            ang = start_q6;
            if (pkt_count > 1) ang += (diff * idx) / (pkt_count - 1);
            bin = (ang / 64) % ANGLE_BINS;
            r.kind = KIND_SAMPLE;
            r.bin = 9'(bin);
            r.distance = {b, low_hold[7:0]};
            dist_table[bin] = r.distance;
            if (r.last) begin
              // walk the table for the smallest entry above the floor
              best = 40000;
              fl = floor_mm_r * 4;
              foreach (dist_table[i])
                if (dist_table[i] > fl && dist_table[i] < best) begin
                  best = dist_table[i];
                  r.min_bin = 9'(i);
                  r.min_found = 1'b1;
                end
              if (r.min_found) begin
                r.min_q2 = 16'(best);
                r.near = (best < near_mm_r * 4);
              end
            end
            expected_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  // Send one byte: bursts with random gaps, held until the transaction.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(b);
  endtask

  task automatic send_word(input int unsigned w);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [13:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SYNC_FIRST:  sync_first_r = val[7:0];
      CFG_SYNC_SECOND: sync_second_r = val[7:0];
      CFG_POINT_TYPE:  point_type_r = val[7:0];
      CFG_REPLY_TYPE:  reply_type_r = val[7:0];
      CFG_FLOOR_MM:    floor_mm_r = val;
      default:         near_mm_r = val;
    endcase
    @(posedge clk);
  endtask

  // Hold until every expected result has drained, then let a table walk finish.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic send_reply(input logic [7:0] type_byte);
    repeat (REPLY_HEADER_BYTES - 1) send_byte(8'($urandom_range(0, 255)));
    send_byte(type_byte);
  endtask

  // One framed packet; distances come from the callers' choice of range.
  task automatic send_packet(input logic [7:0] kind, input int unsigned n,
                             input int unsigned sa, input int unsigned ea,
                             input int unsigned dmax);
    send_byte(sync_first_r);
    send_byte(sync_second_r);
    send_byte(kind);
    send_byte(n[7:0]);
    send_word(sa);
    send_word(ea);
    send_word($urandom_range(0, 65535));
    repeat (n) send_word($urandom_range(0, dmax));
  endtask

  task automatic test_reply_header;
    send_reply(8'h00);
    send_reply(8'hFF);
    send_reply(reply_type_r ^ 8'h01);
    send_reply(reply_type_r);
    drain();
  endtask

  task automatic test_directed_packets;
    send_byte(sync_first_r);            // first sync repeated
    send_packet(point_type_r, 1, 16'hFFFF, 0, 65535);
    send_byte(8'h13);                    // noise between packets
    send_packet(point_type_r, 0, 0, 0, 0);
    send_packet(point_type_r ^ 8'h5A, 3, 0, 100, 65535);
    send_packet(point_type_r, 2, 16'hB3FE, 16'h0002, 1000); // wrap past 360
    send_packet(point_type_r, 4, 1000, 200, 50);           // negative diff
    drain();
  endtask

  task automatic test_random_stream(input int unsigned budget);
    int unsigned sent, n;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        0: begin send_byte(8'($urandom_range(0, 255))); sent++; end
        1: begin  // broken packet: a first sync byte and one random byte
          send_byte(sync_first_r); send_byte(8'($urandom_range(0, 255))); sent += 2;
        end
        2: begin
          n = $urandom_range(0, 6);
          send_packet(8'($urandom_range(0, 255)), n, $urandom_range(0, 65535),
                      $urandom_range(0, 65535), 65535);
          sent += 10 + 2 * n;
        end
        default: begin
          n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 255) : $urandom_range(1, 12);
          send_packet(point_type_r, n, $urandom_range(0, 65535),
                      $urandom_range(0, 65535),
                      ($urandom_range(0, 1) != 0) ? 2000 : 65535);
          sent += 10 + 2 * n;
        end
      endcase
    end
    drain();
  endtask

  task automatic test_configurations;
    write_reg(CFG_SYNC_FIRST, 14'h00);
    write_reg(CFG_SYNC_SECOND, 14'hFF);
    write_reg(CFG_POINT_TYPE, 14'hFF);
    write_reg(CFG_FLOOR_MM, 14'h0);
    write_reg(CFG_NEAR_MM, 14'h3FFF);
    test_random_stream(400);
    write_reg(CFG_SYNC_FIRST, 14'hFF);
    write_reg(CFG_SYNC_SECOND, 14'h00);
    write_reg(CFG_POINT_TYPE, 14'h3C);
    write_reg(CFG_FLOOR_MM, 14'h3FFF);
    write_reg(CFG_NEAR_MM, 14'h0);
    test_random_stream(200);
    write_reg(CFG_SYNC_FIRST, 14'hA5);
    write_reg(CFG_SYNC_SECOND, 14'h5A);
    write_reg(CFG_FLOOR_MM, 14'($urandom_range(0, 500)));
    write_reg(CFG_NEAR_MM, 14'($urandom_range(0, 500)));
    test_random_stream(300);
  endtask

  // Receiver: stall in runs of its own pattern.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (cycle % 64 < 40) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 2) == 0);
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    scan_result_t want;
    cycle <= cycle + 1;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: tdata=%h", m_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.kind) begin
          $error("result_kind exp %0d got %0d", want.kind, m_tuser); errors++;
        end
        if (m_tdata[8:0] !== want.bin) begin
          $error("angle_bin exp %0d got %0d", want.bin, m_tdata[8:0]); errors++;
        end
        if (m_tdata[24:9] !== want.distance) begin
          $error("distance_q2 exp %0d got %0d", want.distance, m_tdata[24:9]); errors++;
        end
        if (m_tlast !== want.last) begin
          $error("packet_last exp %0d got %0d", want.last, m_tlast); errors++;
        end
        if (m_tdata[25] !== want.min_found) begin
          $error("minimum_found exp %0d got %0d", want.min_found, m_tdata[25]); errors++;
        end
        if (m_tdata[41:26] !== want.min_q2) begin
          $error("minimum_q2 exp %0d got %0d", want.min_q2, m_tdata[41:26]); errors++;
        end
        if (m_tdata[50:42] !== want.min_bin) begin
          $error("minimum_bin exp %0d got %0d", want.min_bin, m_tdata[50:42]); errors++;
        end
        if (m_tdata[51] !== want.near) begin
          $error("object_near exp %0d got %0d", want.near, m_tdata[51]); errors++;
        end
      end
    end
    if (cycle >= LIMIT_CYCLES) begin
      $display("timeout with %0d results pending", expected_results.size());
      $display("tb_lidar_scan_packet_decoder_unit: errors");
      $finish;
    end
  end

  initial begin
    sync_first_r = 8'd170; sync_second_r = 8'd85; point_type_r = 8'd0;
    reply_type_r = 8'd129; floor_mm_r = 14'd10; near_mm_r = 14'd200;
    phase = P_REPLY;
    hdr_count = 0; sample_byte = 0; pkt_kind = 0; pkt_count = 0;
    start_q6 = 0; end_q6 = 0; low_hold = 0;
    foreach (dist_table[i]) dist_table[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(CFG_REPLY_TYPE, 14'h00);
    write_reg(CFG_REPLY_TYPE, 14'hFF);
    write_reg(CFG_REPLY_TYPE, 14'd129);
    test_reply_header();
    test_directed_packets();
    test_random_stream(600);
    test_configurations();
    $display("covered reply rejects, sync hunt, foreign and empty packets,");
    $display("angle wrap and table minimum over %0d results", results_seen);
    if (errors == 0) $display("tb_lidar_scan_packet_decoder_unit: clean");
    else $display("tb_lidar_scan_packet_decoder_unit: errors");
    $finish;
  end
endmodule
`default_nettype wire
